>>> rtl/core/assert_macros.svh
// assertion macros for the rtl files, included by sensor_frame_parser_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define SFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent, outside reset
`define SFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sfp_pkg.sv
// package with codes and types for the sensor frame parser
`default_nettype none

package sfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned EventW = 2;
  localparam int unsigned CfgIdxW = 2;

  // parser phases
  localparam logic [PhaseW-1:0] PH_HUNT  = 3'd0;
  localparam logic [PhaseW-1:0] PH_START = 3'd1;
  localparam logic [PhaseW-1:0] PH_BID   = 3'd2;
  localparam logic [PhaseW-1:0] PH_MID   = 3'd3;
  localparam logic [PhaseW-1:0] PH_DATA  = 3'd4;
  localparam logic [PhaseW-1:0] PH_CHECK = 3'd5;

  // result events
  localparam logic [EventW-1:0] EV_NONE    = 2'd0;
  localparam logic [EventW-1:0] EV_PAYLOAD = 2'd1;
  localparam logic [EventW-1:0] EV_GOOD    = 2'd2;
  localparam logic [EventW-1:0] EV_ERROR   = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_BYTE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUS_ID      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [ByteW-1:0] START_BYTE_RST  = 8'd250;
  localparam logic [ByteW-1:0] BUS_ID_RST      = 8'd255;
  localparam logic [ByteW-1:0] MAX_PAYLOAD_RST = 8'd254;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] bus_id;
    logic [ByteW-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  sum;
    logic [ByteW-1:0]  msg_id;
    logic [ByteW-1:0]  length;
    logic [ByteW-1:0]  count;
  } state_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [ByteW-1:0]  payload_byte;
    logic [ByteW-1:0]  payload_index;
    logic [ByteW-1:0]  message_id;
    logic [ByteW-1:0]  frame_length;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/sfp_step.sv
// next-state and result logic of the frame parser for one byte
`default_nettype none

module sfp_step (
  input  wire sfp_pkg::cfg_t    cfg,
  input  wire sfp_pkg::state_t  cur,
  input  wire logic [7:0]       rx_byte,
  output sfp_pkg::state_t       nxt,
  output sfp_pkg::result_t      res
);

  logic [7:0] sum_add;
  logic [7:0] count_inc;

  assign sum_add   = cur.sum + rx_byte;
  assign count_inc = cur.count + 8'd1;

  always_comb begin
    nxt               = cur;
    nxt.sum           = sum_add;
    res.event_res     = sfp_pkg::EV_NONE;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    case (cur.phase)
      sfp_pkg::PH_START: begin
        if (rx_byte == cfg.bus_id) begin
          nxt.phase = sfp_pkg::PH_BID;
        end else begin
          res.event_res = sfp_pkg::EV_ERROR;
          nxt.phase     = sfp_pkg::PH_HUNT;
        end
      end
      sfp_pkg::PH_BID: begin
        nxt.msg_id = rx_byte;
        nxt.phase  = sfp_pkg::PH_MID;
      end
      sfp_pkg::PH_MID: begin
        nxt.length = rx_byte;
        nxt.count  = 8'd0;
        if (rx_byte > cfg.max_payload) begin
          res.event_res = sfp_pkg::EV_ERROR;
          nxt.phase     = sfp_pkg::PH_HUNT;
        end else if (rx_byte == 8'd0) begin
          nxt.phase = sfp_pkg::PH_CHECK;
        end else begin
          nxt.phase = sfp_pkg::PH_DATA;
        end
      end
      sfp_pkg::PH_DATA: begin
        res.event_res     = sfp_pkg::EV_PAYLOAD;
        res.payload_byte  = rx_byte;
        res.payload_index = cur.count;
        nxt.count         = count_inc;
        if (count_inc >= cur.length) begin
          nxt.phase = sfp_pkg::PH_CHECK;
        end
      end
      sfp_pkg::PH_CHECK: begin
        // sum includes the checksum byte itself
        res.event_res = (sum_add == 8'd0) ? sfp_pkg::EV_GOOD : sfp_pkg::EV_ERROR;
        nxt.phase     = sfp_pkg::PH_HUNT;
      end
      default: begin
        // hunting, unused codes act the same
        if (rx_byte == cfg.start_byte) begin
          nxt.phase = sfp_pkg::PH_START;
          nxt.sum   = 8'd0;
        end else begin
          nxt.phase = sfp_pkg::PH_HUNT;
        end
      end
    endcase
    res.message_id   = nxt.msg_id;
    res.frame_length = nxt.length;
  end

endmodule

`default_nettype wire

>>> rtl/core/sensor_frame_parser_core.sv
// top level of the byte-serial sensor frame parser
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_valid/in_stall   | rx_byte
//   out_    | out | out_valid/out_stall | event_res, payload_byte/index, message_id, frame_length
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word per cycle sustained while out_stall is low; each word is first captured in the input register,
// then the parser state and result register update together
// every accepted word yields exactly one result word
// rst_n is synchronous; it clears the parser state and the valid flags and restores
// the register defaults; cfg_ready is always high
// out_stall holds the result register; in_stall is high only while both stages are full
`default_nettype none
`include "assert_macros.svh"

module sensor_frame_parser_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_event_res,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index,
  output logic [7:0]      out_message_id,
  output logic [7:0]      out_frame_length,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  sfp_pkg::cfg_t    cfg_r;
  sfp_pkg::state_t  state_r;
  sfp_pkg::state_t  state_nxt;
  sfp_pkg::result_t res_nxt;
  sfp_pkg::result_t res_r;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic       out_free;
  logic       adv;
  logic       in_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= sfp_pkg::START_BYTE_RST;
      cfg_r.bus_id      <= sfp_pkg::BUS_ID_RST;
      cfg_r.max_payload <= sfp_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfp_pkg::CFG_START_BYTE:  cfg_r.start_byte  <= cfg_data;
        sfp_pkg::CFG_BUS_ID:      cfg_r.bus_id      <= cfg_data;
        sfp_pkg::CFG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register drains or is empty
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  sfp_step u_step (
    .cfg     (cfg_r),
    .cur     (state_r),
    .rx_byte (s1_byte_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= adv || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = res_r.event_res;
  assign out_payload_byte  = res_r.payload_byte;
  assign out_payload_index = res_r.payload_index;
  assign out_message_id    = res_r.message_id;
  assign out_frame_length  = res_r.frame_length;

  `SFP_ASSERT(a_count_in_range,
    (state_r.phase != sfp_pkg::PH_DATA) || (state_r.count < state_r.length),
    "payload count reached length while still in data phase")

  `SFP_ASSERT(a_index_below_len,
    !(out_valid_r && (res_r.event_res == sfp_pkg::EV_PAYLOAD)) ||
      (res_r.payload_index < res_r.frame_length),
    "payload index not below frame length")

  `SFP_ASSERT_NEXT(a_check_to_hunt,
    adv && (state_r.phase == sfp_pkg::PH_CHECK),
    state_r.phase == sfp_pkg::PH_HUNT,
    "parser did not return to hunting after checksum")

  `SFP_ASSERT_NEXT(a_result_follows,
    adv,
    out_valid_r,
    "advanced word produced no result")

endmodule

`default_nettype wire

>>> test/frame_result_checker.sv
// result predictor and scoreboard for the sensor frame parser channels
module frame_result_checker
  import sfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_event_res,
  input  logic [7:0] out_payload_byte,
  input  logic [7:0] out_payload_index,
  input  logic [7:0] out_message_id,
  input  logic [7:0] out_frame_length,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         outstanding
);

  logic [7:0] cfg_start;
  logic [7:0] cfg_bus;
  logic [7:0] cfg_max;

  logic [PhaseW-1:0] parse_phase;
  logic [7:0]        frame_sum;
  logic [7:0]        frame_id;
  logic [7:0]        frame_len;
  logic [7:0]        data_count;

  result_t expected_results[$];

  function automatic result_t parse_byte(input logic [7:0] rx);
    result_t r;
    r = '0;
    r.event_res = EV_NONE;
    frame_sum = frame_sum + rx;
    case (parse_phase)
      PH_START: begin
        if (rx == cfg_bus) begin
          parse_phase = PH_BID;
        end else begin
          r.event_res = EV_ERROR;
          parse_phase = PH_HUNT;
        end
      end
      PH_BID: begin
        frame_id = rx;
        parse_phase = PH_MID;
      end
      PH_MID: begin
        frame_len = rx;
        data_count = '0;
        if (rx > cfg_max) begin
          r.event_res = EV_ERROR;
          parse_phase = PH_HUNT;
        end else if (rx == 8'd0) begin
          parse_phase = PH_CHECK;
        end else begin
          parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        r.event_res = EV_PAYLOAD;
        r.payload_byte = rx;
        r.payload_index = data_count;
        data_count = data_count + 8'd1;
        if (data_count >= frame_len) parse_phase = PH_CHECK;
      end
      PH_CHECK: begin
        r.event_res = (frame_sum == 8'd0) ? EV_GOOD : EV_ERROR;
        parse_phase = PH_HUNT;
      end
      default: begin
        // unused phase codes behave like hunting
        if (rx == cfg_start) begin
          parse_phase = PH_START;
          frame_sum = '0;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
    endcase
    r.message_id = frame_id;
    r.frame_length = frame_len;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      cfg_start   = START_BYTE_RST;
      cfg_bus     = BUS_ID_RST;
      cfg_max     = MAX_PAYLOAD_RST;
      parse_phase = PH_HUNT;
      frame_sum   = '0;
      frame_id    = '0;
      frame_len   = '0;
      data_count  = '0;
      mismatches  = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_BYTE:  cfg_start = cfg_data;
          CFG_BUS_ID:      cfg_bus = cfg_data;
          CFG_MAX_PAYLOAD: cfg_max = cfg_data;
          default: ;
        endcase
      end
      // retire before predicting so a word never meets its own expectation
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation pending: event_res %0d", out_event_res);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("event_res", want.event_res, out_event_res);
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("payload_index", want.payload_index, out_payload_index);
          check_field("message_id", want.message_id, out_message_id);
          check_field("frame_length", want.frame_length, out_frame_length);
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(parse_byte(in_rx_byte));
    end
    outstanding = expected_results.size();
  end

endmodule

>>> test/sensor_frame_parser_core_tb.sv
// testbench top: drives frames, config writes and backpressure into the frame parser
module sensor_frame_parser_core_tb;
  import sfp_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [1:0] cfg_index = CFG_START_BYTE;
  logic [7:0] cfg_data = 8'd0;

  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_event_res;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic [7:0] out_message_id;
  logic [7:0] out_frame_length;
  logic       cfg_ready;

  int mismatches;
  int outstanding;

  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned sent_count = 0;

  // stimulus copy of the register settings, used to build frames
  logic [7:0] cur_start = START_BYTE_RST;
  logic [7:0] cur_bus = BUS_ID_RST;
  logic [7:0] cur_max = MAX_PAYLOAD_RST;

  always #1 clk = ~clk;

  sensor_frame_parser_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_message_id    (out_message_id),
    .out_frame_length  (out_frame_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  frame_result_checker results_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_message_id    (out_message_id),
    .out_frame_length  (out_frame_length),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin : watchdog
    #800000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the parser backs up into its input
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= idle_on && ($urandom_range(99) < 32);
    end
  end

  task automatic send_byte(input logic [7:0] rx);
    while (idle_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // drop valid and wait until every result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
  endtask

  task automatic configure(input logic [7:0] sb, input logic [7:0] bid, input logic [7:0] mp);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data <= sb;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_BUS_ID;
    cfg_data <= bid;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data <= mp;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_start = sb;
    cur_bus = bid;
    cur_max = mp;
  endtask

  // keep of zero sends the whole frame, otherwise only the first keep words
  task automatic send_frame(input logic [7:0] bus, input logic [7:0] len, input bit bad_sum,
                            input int unsigned keep);
    logic [7:0]  frame_q[$];
    logic [7:0]  sum;
    logic [7:0]  data;
    int unsigned last;
    frame_q.push_back(cur_start);
    frame_q.push_back(bus);
    data = 8'($urandom);
    frame_q.push_back(data);
    sum = bus + data;
    frame_q.push_back(len);
    sum = sum + len;
    if (len <= cur_max) begin
      for (int i = 0; i < len; i++) begin
        data = 8'($urandom);
        frame_q.push_back(data);
        sum = sum + data;
      end
      data = -sum;
      if (bad_sum) data = data ^ 8'($urandom_range(255, 1));
      frame_q.push_back(data);
    end
    last = (keep == 0 || keep > frame_q.size()) ? frame_q.size() : keep;
    for (int i = 0; i < last; i++) send_byte(frame_q[i]);
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    logic [7:0]  lim;
    logic [7:0]  len;
    target = sent_count + count;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      lim = (cur_max < 8'd12) ? cur_max : 8'd12;
      // mostly short frames, now and then one up to the limit
      len = ($urandom_range(9) == 0) ? 8'($urandom_range(cur_max)) : 8'($urandom_range(lim));
      if (pick < 70) begin
        send_frame(cur_bus, len, 1'b0, 0);
      end else if (pick < 76) begin
        send_frame(cur_bus, len, 1'b1, 0);
      end else if (pick < 81) begin
        send_frame(cur_bus ^ 8'($urandom_range(255, 1)), len, 1'b0, 2);
      end else if (pick < 86 && cur_max != 8'hFF) begin
        send_frame(cur_bus, 8'($urandom_range(255, int'(cur_max) + 1)), 1'b0, 0);
      end else if (pick < 91) begin
        send_frame(cur_bus, len, 1'b0, $urandom_range(int'(len) + 4, 1));
      end else begin
        repeat ($urandom_range(4, 1))
          send_byte(($urandom_range(3) == 0) ? cur_start : 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] chk;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle words while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // bus id byte equal to the start byte is an error, not a restart
    send_byte(cur_start);
    send_byte(cur_start);
    send_frame(cur_bus, 8'd0, 1'b0, 0);
    send_frame(cur_bus, 8'hFF, 1'b0, 0);
    chk = -(cur_bus + 8'h81 + 8'd2 + 8'h00 + 8'hFF);
    send_byte(cur_start);
    send_byte(cur_bus);
    send_byte(8'h81);
    send_byte(8'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(chk);
    send_frame(cur_bus, 8'd1, 1'b1, 0);
    drain();

    idle_on = 1'b0;
    random_traffic(80);
    idle_on = 1'b1;
    random_traffic(100);
    drain();
    random_traffic(80);

    configure(8'h00, 8'h00, 8'h00);
    random_traffic(120);

    configure(8'hFF, 8'hFF, 8'hFF);
    send_frame(cur_bus, 8'hFF, 1'b0, 0);
    random_traffic(60);

    configure(8'($urandom), 8'($urandom), 8'($urandom_range(40, 1)));
    hold_req = 1'b1;
    random_traffic(200);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
